[rtl/kfwrl_pkg.sv]
// shared types, constants and register codes for the keyed fixed-window rate limiter
package kfwrl_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 64;
	localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// configuration reset values
	localparam logic [31:0] WINDOW_LENGTH_RST  = 32'd60;
	localparam logic [15:0] LIMIT_LOW_RST      = 16'd10;
	localparam logic [15:0] LIMIT_NORMAL_RST   = 16'd60;
	localparam logic [15:0] LIMIT_HIGH_RST     = 16'd300;
	localparam logic [15:0] LIMIT_CRITICAL_RST = 16'd1000;
	localparam logic        SCORE_SRC_ON_RST   = 1'b1;

	// reputation scale
	localparam logic [6:0] REP_ZERO          = 7'd0;
	localparam logic [6:0] REP_NEUTRAL       = 7'd50;
	localparam logic [6:0] REP_MAX           = 7'd100;
	localparam logic [6:0] REP_TIER_CRITICAL = 7'd90;
	localparam logic [6:0] REP_TIER_HIGH     = 7'd70;
	localparam logic [6:0] REP_TIER_NORMAL   = 7'd50;

	// score / 200 = (score >> 3) / 25; magnitudes at or above 2**14 always clamp
	localparam int          SCORE_CLAMP_BIT = 14;
	localparam int          SCORE_PRE_SHIFT = 3;
	localparam logic [11:0] RECIP_25        = 12'd2622;
	localparam int          RECIP_SHIFT     = 16;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		FUNC_CHECK  = 2'd0,
		FUNC_RECORD = 2'd1,
		FUNC_QUERY  = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH  = 3'd0,
		REG_LIMIT_LOW      = 3'd1,
		REG_LIMIT_NORMAL   = 3'd2,
		REG_LIMIT_HIGH     = 3'd3,
		REG_LIMIT_CRITICAL = 3'd4,
		REG_SCORE_SRC_ON   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] low;
		logic [15:0] normal;
		logic [15:0] high;
		logic [15:0] critical;
	} tier_limits_t;

	// one request as seen by the table stage
	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] key_high;
		logic [63:0] key_middle;
		logic [63:0] key_low;
		logic [31:0] now;
		logic [6:0]  rep;
		logic [15:0] lim;
	} req_t;

	// one result item
	typedef struct packed {
		logic        allowed;
		logic        throttled;
		logic [15:0] call_limit;
		logic [31:0] call_count;
		logic [6:0]  reputation;
		logic        entry_existed;
		logic        table_full;
	} res_t;

endpackage

[rtl/kfwrl_rep.sv]
// reputation from the signed score and tier limit selection
module kfwrl_rep import kfwrl_pkg::*; (
	input  logic               score_found,
	input  logic signed [31:0] score,
	input  logic               src_on,
	input  tier_limits_t       limits,
	output logic [6:0]         rep,
	output logic [15:0]        lim
);

	logic        neg;
	logic [31:0] mag;
	logic        big;
	logic [10:0] pre;
	logic [22:0] prod;
	logic [6:0]  quo;

	assign neg  = score[31];
	assign mag  = neg ? (~score + 32'd1) : score;
	assign big  = |mag[31:SCORE_CLAMP_BIT];
	assign pre  = mag[SCORE_CLAMP_BIT-1:SCORE_PRE_SHIFT];
	// exact floor(pre / 25) for pre below 2**11
	assign prod = 23'(pre) * 23'(RECIP_25);
	assign quo  = prod[22:RECIP_SHIFT];

	always_comb begin
		if (!src_on) begin
			rep = REP_ZERO;
		end else if (!score_found) begin
			rep = REP_NEUTRAL;
		end else if (neg) begin
			rep = (big || quo >= REP_NEUTRAL) ? REP_ZERO : (REP_NEUTRAL - quo);
		end else begin
			rep = (big || quo >= REP_NEUTRAL) ? REP_MAX : (REP_NEUTRAL + quo);
		end
	end

	always_comb begin
		priority if (rep >= REP_TIER_CRITICAL) begin
			lim = limits.critical;
		end else if (rep >= REP_TIER_HIGH) begin
			lim = limits.high;
		end else if (rep >= REP_TIER_NORMAL) begin
			lim = limits.normal;
		end else begin
			lim = limits.low;
		end
	end

endmodule

[rtl/kfwrl_table.sv]
// key table: register cam, entry update and result formation
module kfwrl_table import kfwrl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd,
	input  req_t        req,
	input  logic [31:0] window_length,
	output res_t        res
);

	logic [31:0]       kh_q   [TABLE_ENTRIES];
	logic [63:0]       km_q   [TABLE_ENTRIES];
	logic [63:0]       kl_q   [TABLE_ENTRIES];
	logic [31:0]       ws_q   [TABLE_ENTRIES];
	logic [31:0]       cnt_q  [TABLE_ENTRIES];
	logic [6:0]        rep_q  [TABLE_ENTRIES];
	logic [15:0]       lim_q  [TABLE_ENTRIES];
	logic              thr_q  [TABLE_ENTRIES];
	logic [FILL_W-1:0] fill_q;

	logic [TABLE_ENTRIES-1:0] hit;
	logic [TABLE_ENTRIES-1:0] wen;
	logic        hit_any;
	logic        full;
	logic        upd_func;
	logic        is_check;
	logic        is_record;
	logic        due;
	logic        alloc;
	logic [31:0] sel_ws, sel_cnt;
	logic [6:0]  sel_rep;
	logic [15:0] sel_lim;
	logic        sel_thr;
	logic [31:0] base_ws, base_cnt;
	logic [6:0]  base_rep;
	logic [15:0] base_lim;
	logic        base_thr;
	logic [31:0] n_ws, n_cnt;
	logic [6:0]  n_rep;
	logic [15:0] n_lim;
	logic        n_thr;

	// slots fill from the bottom and are never freed, so a count marks validity
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit[i] = (FILL_W'(i) < fill_q) && kh_q[i] == req.key_high &&
				km_q[i] == req.key_middle && kl_q[i] == req.key_low;
		end
	end

	// keys are unique, so the hit vector is one-hot or empty
	always_comb begin
		sel_ws  = '0;
		sel_cnt = '0;
		sel_rep = '0;
		sel_lim = '0;
		sel_thr = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			sel_ws  = sel_ws  | ({32{hit[i]}} & ws_q[i]);
			sel_cnt = sel_cnt | ({32{hit[i]}} & cnt_q[i]);
			sel_rep = sel_rep | ({7{hit[i]}} & rep_q[i]);
			sel_lim = sel_lim | ({16{hit[i]}} & lim_q[i]);
			sel_thr = sel_thr | (hit[i] & thr_q[i]);
		end
	end

	assign hit_any   = |hit;
	assign full      = (fill_q == FILL_W'(TABLE_ENTRIES));
	assign is_check  = (req.func == FUNC_CHECK);
	assign is_record = (req.func == FUNC_RECORD);
	assign upd_func  = is_check || is_record;
	assign due       = (req.now >= sel_ws) && ((req.now - sel_ws) >= window_length);

	// window renewal ahead of the function itself
	always_comb begin
		if (due && upd_func) begin
			base_ws  = req.now;
			base_cnt = '0;
			base_rep = req.rep;
			base_lim = req.lim;
			base_thr = 1'b0;
		end else begin
			base_ws  = sel_ws;
			base_cnt = sel_cnt;
			base_rep = sel_rep;
			base_lim = sel_lim;
			base_thr = sel_thr;
		end
	end

	always_comb begin
		alloc = 1'b0;
		n_ws  = base_ws;
		n_cnt = base_cnt;
		n_rep = base_rep;
		n_lim = base_lim;
		n_thr = base_thr;
		res.allowed       = 1'b0;
		res.throttled     = 1'b0;
		res.call_limit    = req.lim;
		res.call_count    = '0;
		res.reputation    = req.rep;
		res.entry_existed = 1'b0;
		res.table_full    = 1'b0;
		if (hit_any) begin
			if (is_check) begin
				n_thr = (base_cnt >= {16'd0, base_lim});
				res.allowed = !n_thr;
			end else if (is_record) begin
				n_cnt = (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + 32'd1;
			end
			res.throttled     = n_thr;
			res.call_limit    = n_lim;
			res.call_count    = n_cnt;
			res.reputation    = n_rep;
			res.entry_existed = 1'b1;
		end else if (upd_func) begin
			if (full) begin
				res.table_full = 1'b1;
			end else begin
				alloc = 1'b1;
				n_ws  = req.now;
				n_cnt = is_record ? 32'd1 : 32'd0;
				n_rep = req.rep;
				n_lim = req.lim;
				n_thr = is_check && (req.lim == 16'd0);
				res.allowed    = is_check && (req.lim != 16'd0);
				res.throttled  = n_thr;
				res.call_count = n_cnt;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			wen[i] = upd && ((hit[i] && upd_func) || (alloc && fill_q == FILL_W'(i)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (upd && alloc) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	// entry payload, written in place on a check or record hit or at the next free slot
	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (wen[i]) begin
				kh_q[i]  <= req.key_high;
				km_q[i]  <= req.key_middle;
				kl_q[i]  <= req.key_low;
				ws_q[i]  <= n_ws;
				cnt_q[i] <= n_cnt;
				rep_q[i] <= n_rep;
				lim_q[i] <= n_lim;
				thr_q[i] <= n_thr;
			end
		end
	end

endmodule

[rtl/keyed_fixed_window_rate_limiter_top.sv]
// pipeline: a request passes through the input register, the stage 2 register and the output register
// throughput: one request per cycle while the result channel is not stalled, including back-to-back
//   requests to the same key, set by the cam lookup and in-place entry write together in the table stage
// reset: arst_n clears the pipeline valids, the table fill count (table empty) and
//   loads the configuration registers with their defaults; no clearing pass is needed
module keyed_fixed_window_rate_limiter_top import kfwrl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic [31:0]           key_high,
	input  logic [63:0]           key_middle,
	input  logic [63:0]           key_low,
	input  logic [31:0]           now_seconds,
	input  logic                  score_found,
	input  logic signed [31:0]    score,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  allowed,
	output logic                  throttled,
	output logic [15:0]           call_limit,
	output logic [31:0]           call_count,
	output logic [6:0]            reputation,
	output logic                  entry_existed,
	output logic                  table_full
);

	// configuration registers
	logic [31:0]  window_length_q;
	tier_limits_t limits_q;
	logic         src_on_q;

	// stage 1: raw request
	logic               valid_s1;
	logic [1:0]         func_s1;
	logic [31:0]        key_high_s1;
	logic [63:0]        key_middle_s1;
	logic [63:0]        key_low_s1;
	logic [31:0]        now_s1;
	logic               found_s1;
	logic signed [31:0] score_s1;

	// stage 2: request with reputation and tier limit resolved
	logic valid_s2;
	req_t req_s2;

	// output register
	logic out_valid_q;
	res_t res_q;

	logic        load_out;
	logic        move_s2;
	logic        load_s2;
	logic        move_s1;
	logic        load_s1;
	logic [6:0]  rep_s1;
	logic [15:0] lim_s1;
	res_t        tbl_res;

	// configuration is always accepted; writes are expected only while the block is idle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q   <= WINDOW_LENGTH_RST;
			limits_q.low      <= LIMIT_LOW_RST;
			limits_q.normal   <= LIMIT_NORMAL_RST;
			limits_q.high     <= LIMIT_HIGH_RST;
			limits_q.critical <= LIMIT_CRITICAL_RST;
			src_on_q          <= SCORE_SRC_ON_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH:  window_length_q   <= cfg_data;
				REG_LIMIT_LOW:      limits_q.low      <= cfg_data[15:0];
				REG_LIMIT_NORMAL:   limits_q.normal   <= cfg_data[15:0];
				REG_LIMIT_HIGH:     limits_q.high     <= cfg_data[15:0];
				REG_LIMIT_CRITICAL: limits_q.critical <= cfg_data[15:0];
				REG_SCORE_SRC_ON:   src_on_q          <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stall chain: each stage loads when it is empty or its content moves on
	assign load_out = !out_valid_q || out_ready;
	assign move_s2  = valid_s2 && load_out;
	assign load_s2  = !valid_s2 || move_s2;
	assign move_s1  = valid_s1 && load_s2;
	assign load_s1  = !valid_s1 || move_s1;
	assign in_ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= move_s1;
			end
			if (load_out) begin
				out_valid_q <= move_s2;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && load_s1) begin
			func_s1       <= func;
			key_high_s1   <= key_high;
			key_middle_s1 <= key_middle;
			key_low_s1    <= key_low;
			now_s1        <= now_seconds;
			found_s1      <= score_found;
			score_s1      <= score;
		end
	end

	// reputation and limit from the current tier registers
	kfwrl_rep u_rep (
		.score_found (found_s1),
		.score       (score_s1),
		.src_on      (src_on_q),
		.limits      (limits_q),
		.rep         (rep_s1),
		.lim         (lim_s1)
	);

	always_ff @(posedge clk) begin
		if (move_s1) begin
			req_s2.func       <= func_s1;
			req_s2.key_high   <= key_high_s1;
			req_s2.key_middle <= key_middle_s1;
			req_s2.key_low    <= key_low_s1;
			req_s2.now        <= now_s1;
			req_s2.rep        <= rep_s1;
			req_s2.lim        <= lim_s1;
		end
	end

	// table stage: lookup, update and result together, with the entry written as the request moves on, so the next request
	// in line already sees this request's write
	kfwrl_table u_table (
		.clk           (clk),
		.arst_n        (arst_n),
		.upd           (move_s2),
		.req           (req_s2),
		.window_length (window_length_q),
		.res           (tbl_res)
	);

	always_ff @(posedge clk) begin
		if (move_s2) begin
			res_q <= tbl_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign allowed       = res_q.allowed;
	assign throttled     = res_q.throttled;
	assign call_limit    = res_q.call_limit;
	assign call_count    = res_q.call_count;
	assign reputation    = res_q.reputation;
	assign entry_existed = res_q.entry_existed;
	assign table_full    = res_q.table_full;

endmodule

[rtl/kfwrl_checker.sv]
// port-level checks for the rate limiter and their bind to the top level
module kfwrl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        allowed,
	input logic        throttled,
	input logic [15:0] call_limit,
	input logic [31:0] call_count,
	input logic [6:0]  reputation,
	input logic        entry_existed,
	input logic        table_full
);

	// an allowed call was below its limit and cannot be throttled or denied
	a_allowed_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && allowed |-> !throttled && !table_full && (call_count < {16'd0, call_limit}))
		else $error("allowed result not below its limit");

	// a full-table denial stores nothing and reports an empty entry
	a_full_denies: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |->
			!entry_existed && !allowed && !throttled && call_count == 32'd0)
		else $error("table full result not a clean denial");

	// a fresh or absent entry has seen at most the call of this request
	a_new_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_existed |-> call_count <= 32'd1)
		else $error("new entry with too many calls");

	a_rep_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reputation <= 7'd100)
		else $error("reputation out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(call_count) && $stable(allowed))
		else $error("stalled result changed");

endmodule

bind keyed_fixed_window_rate_limiter_top kfwrl_checker u_kfwrl_checker (.*);
